### sv/sla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_pkg: shared types and constants for the advection cell
// Item, command and status structs, controller states and fixed-point widths.
// ----------------------------------------------------------------------------
package sla_pkg;

  localparam int COORD_W   = 7;
  localparam int VAL_W     = 24;
  localparam int VEL_W     = 16;
  localparam int RATE_W    = 16;
  localparam int FRAC_W    = 8;
  localparam int PROD_W    = RATE_W + 1 + VEL_W;
  localparam int POS_W     = 27;
  localparam int OMW_W     = FRAC_W + 1;
  localparam int WGT_W     = 2 * FRAC_W + 1;
  localparam int MAC_W     = WGT_W + 1 + VAL_W;
  localparam int ACC_W     = MAC_W + 2;
  localparam int RND_SHIFT = 2 * FRAC_W;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ADVECT = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic [COORD_W-1:0]       cell_x;
    logic [COORD_W-1:0]       cell_y;
    logic signed [VAL_W-1:0]  source_value;
    logic                     wall_bit;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]       out_x;
    logic [COORD_W-1:0]       out_y;
    logic signed [VAL_W-1:0]  advected_value;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_VMUL,
    ST_POS,
    ST_WGT,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_MAC3,
    ST_ACC3,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    NB_LL,
    NB_LH,
    NB_HL,
    NB_HH
  } nbr_t;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic clr_en;
    logic vel_mul;
    logic pos_en;
    logic wgt_en;
    logic rd_en;
    nbr_t rd_sel;
    logic mac_en;
    nbr_t mac_sel;
    logic acc_clr;
    logic acc_en;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

### sv/semi_lagrangian_advect_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semi_lagrangian_advect_cell: one-cell semi-Lagrangian advection
// Backtrace, clamp and bilinear interpolation over a stored source grid.
// ----------------------------------------------------------------------------
// In an advect transaction the four
// neighbor reads share the single source-store read port, one per cycle.
// A new load or advect is taken only once busy has dropped after the last one.
// After reset busy stays high through the clearing pass, while the wall store is
// swept one row per cycle; configuration writes are taken during that pass.
// The receiver cannot stall: each result is strobed by out_valid for one cycle.
module semi_lagrangian_advect_cell #(
  parameter int GRID_SIZE = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  sla_pkg::in_item_t           in_data,
  input  logic                        cfg_we,
  input  logic [sla_pkg::RATE_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  output sla_pkg::out_item_t          out_data
);

  sla_pkg::cmd_t cmd;
  sla_pkg::sts_t sts;

  sla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op_advect (in_data.opcode == sla_pkg::OP_ADVECT),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  sla_dpath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### sv/sla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_ctrl: sequencer for the advection cell
// Walks the wall-store clearing pass, loads, and the advect sequence.
// ----------------------------------------------------------------------------
module sla_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          op_advect,
  input  sla_pkg::sts_t sts,
  output logic          busy,
  output sla_pkg::cmd_t cmd
);

  sla_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sla_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sla_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = sla_pkg::ST_IDLE;
      end
      sla_pkg::ST_IDLE: begin
        if (start) state_nxt = op_advect ? sla_pkg::ST_VMUL : sla_pkg::ST_LOAD;
      end
      sla_pkg::ST_LOAD: state_nxt = sla_pkg::ST_IDLE;
      sla_pkg::ST_VMUL: state_nxt = sla_pkg::ST_POS;
      sla_pkg::ST_POS:  state_nxt = sla_pkg::ST_WGT;
      sla_pkg::ST_WGT:  state_nxt = sla_pkg::ST_RD0;
      sla_pkg::ST_RD0:  state_nxt = sla_pkg::ST_RD1;
      sla_pkg::ST_RD1:  state_nxt = sla_pkg::ST_RD2;
      sla_pkg::ST_RD2:  state_nxt = sla_pkg::ST_RD3;
      sla_pkg::ST_RD3:  state_nxt = sla_pkg::ST_MAC3;
      sla_pkg::ST_MAC3: state_nxt = sla_pkg::ST_ACC3;
      sla_pkg::ST_ACC3: state_nxt = sla_pkg::ST_FIN;
      sla_pkg::ST_FIN:  state_nxt = sla_pkg::ST_IDLE;
      default:          state_nxt = sla_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = sla_pkg::NB_LL;
    cmd.mac_sel = sla_pkg::NB_LL;
    unique case (state_r)
      sla_pkg::ST_CLEAR: cmd.clr_en = 1'b1;
      sla_pkg::ST_IDLE:  cmd.capture = start;
      sla_pkg::ST_LOAD:  cmd.load_wr = 1'b1;
      sla_pkg::ST_VMUL:  cmd.vel_mul = 1'b1;
      sla_pkg::ST_POS:   cmd.pos_en = 1'b1;
      sla_pkg::ST_WGT:   cmd.wgt_en = 1'b1;
      sla_pkg::ST_RD0: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = sla_pkg::NB_LL;
        cmd.acc_clr = 1'b1;
      end
      sla_pkg::ST_RD1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = sla_pkg::NB_LH;
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = sla_pkg::NB_LL;
      end
      sla_pkg::ST_RD2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = sla_pkg::NB_HL;
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = sla_pkg::NB_LH;
        cmd.acc_en  = 1'b1;
      end
      sla_pkg::ST_RD3: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = sla_pkg::NB_HH;
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = sla_pkg::NB_HL;
        cmd.acc_en  = 1'b1;
      end
      sla_pkg::ST_MAC3: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = sla_pkg::NB_HH;
        cmd.acc_en  = 1'b1;
      end
      sla_pkg::ST_ACC3: cmd.acc_en = 1'b1;
      sla_pkg::ST_FIN:  cmd.fin = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state_r != sla_pkg::ST_IDLE);

  a_advect_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sla_pkg::ST_IDLE && start && op_advect) |-> ##10 (state_r == sla_pkg::ST_FIN))
    else $error("advect transaction did not reach the final state on time");

  a_load_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sla_pkg::ST_IDLE && start && !op_advect) |-> ##2 (state_r == sla_pkg::ST_IDLE))
    else $error("load transaction did not return to idle");

endmodule

### sv/sla_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sla_dpath: datapath of the advection cell
// Source and wall stores, backtrace, clamping, weights and bilinear blend.
// ----------------------------------------------------------------------------
module sla_dpath #(
  parameter int GRID_SIZE = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sla_pkg::cmd_t                cmd,
  output sla_pkg::sts_t                sts,
  input  sla_pkg::in_item_t            in_data,
  input  logic                         cfg_we,
  input  logic [sla_pkg::RATE_W-1:0]   cfg_wdata,
  output logic                         out_valid,
  output sla_pkg::out_item_t           out_data
);

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int PW    = CW + sla_pkg::FRAC_W;

  localparam logic signed [sla_pkg::POS_W-1:0] POS_LO = sla_pkg::POS_W'(128);
  localparam logic signed [sla_pkg::POS_W-1:0] POS_HI =
    sla_pkg::POS_W'(GRID_SIZE * 256 - 384);
  localparam logic [GRID_SIZE-1:0] EDGE_ROW = {1'b1, {(GRID_SIZE-2){1'b0}}, 1'b1};
  localparam logic [GRID_SIZE-1:0] FULL_ROW = '1;
  localparam logic signed [sla_pkg::ACC_W-1:0] RND_HALF =
    sla_pkg::ACC_W'(1 << (sla_pkg::RND_SHIFT - 1));
  localparam logic signed [sla_pkg::ACC_W-1:0] VAL_MAX =
    sla_pkg::ACC_W'((1 << (sla_pkg::VAL_W - 1)) - 1);
  localparam logic signed [sla_pkg::ACC_W-1:0] VAL_MIN = -(VAL_MAX + 1);
  localparam logic [sla_pkg::OMW_W-1:0] ONE_FRAC = sla_pkg::OMW_W'(1 << sla_pkg::FRAC_W);

  logic signed [sla_pkg::VAL_W-1:0]  src_mem [DEPTH];
  logic [GRID_SIZE-1:0]              wall_mem [GRID_SIZE];

  sla_pkg::in_item_t                 item_r;
  logic [sla_pkg::RATE_W-1:0]        rate_r;
  logic [CW-1:0]                     clr_cnt_r;
  logic [GRID_SIZE-1:0]              wall_row_r;
  logic signed [sla_pkg::PROD_W-1:0] dispx_prod_r, dispy_prod_r;
  logic [CW-1:0]                     i0_r, j0_r;
  logic [sla_pkg::FRAC_W-1:0]        fx_r, fy_r;
  logic                              live_r;
  logic [sla_pkg::WGT_W-1:0]         wgt_r [4];
  logic signed [sla_pkg::VAL_W-1:0]  rdata_r;
  logic signed [sla_pkg::MAC_W-1:0]  mult_r;
  logic signed [sla_pkg::ACC_W-1:0]  acc_r;
  sla_pkg::out_item_t                out_data_r;
  logic                              out_valid_r;

  logic [CW-1:0]                     cx_idx, cy_idx;
  logic                              in_grid, on_border;
  logic [AW-1:0]                     rd_addr;
  logic [sla_pkg::OMW_W-1:0]         omx, omy;
  logic signed [sla_pkg::ACC_W-1:0]  rnd_sum, scaled;
  logic signed [sla_pkg::VAL_W-1:0]  sat_val;

  function automatic logic [PW-1:0] trace_pos(
    input logic [sla_pkg::COORD_W-1:0]       c,
    input logic signed [sla_pkg::PROD_W-1:0] prod
  );
    logic signed [sla_pkg::POS_W-1:0] base;
    logic signed [sla_pkg::POS_W-1:0] disp;
    logic signed [sla_pkg::POS_W-1:0] pos;
    base = $signed(sla_pkg::POS_W'({c, sla_pkg::FRAC_W'(0)}));
    disp = sla_pkg::POS_W'($signed(prod[sla_pkg::PROD_W-1:sla_pkg::FRAC_W]));
    pos  = base - disp;
    if (pos < POS_LO) begin
      pos = POS_LO;
    end else if (pos > POS_HI) begin
      pos = POS_HI;
    end
    return pos[PW-1:0];
  endfunction

  assign cx_idx    = CW'(item_r.cell_x);
  assign cy_idx    = CW'(item_r.cell_y);
  assign in_grid   = (32'(item_r.cell_x) < GRID_SIZE) && (32'(item_r.cell_y) < GRID_SIZE);
  assign on_border = (item_r.cell_x == '0) || (item_r.cell_y == '0) ||
                     (32'(item_r.cell_x) == GRID_SIZE - 1) ||
                     (32'(item_r.cell_y) == GRID_SIZE - 1);
  assign sts.clr_last = (clr_cnt_r == CW'(GRID_SIZE - 1));

  always_comb begin
    case (cmd.rd_sel)
      sla_pkg::NB_LL: rd_addr = {i0_r, j0_r};
      sla_pkg::NB_LH: rd_addr = {i0_r, j0_r + CW'(1)};
      sla_pkg::NB_HL: rd_addr = {i0_r + CW'(1), j0_r};
      sla_pkg::NB_HH: rd_addr = {i0_r + CW'(1), j0_r + CW'(1)};
      default:        rd_addr = {i0_r, j0_r};
    endcase
  end

  assign omx = ONE_FRAC - sla_pkg::OMW_W'(fx_r);
  assign omy = ONE_FRAC - sla_pkg::OMW_W'(fy_r);

  assign rnd_sum = acc_r + RND_HALF;
  assign scaled  = rnd_sum >>> sla_pkg::RND_SHIFT;

  always_comb begin
    if (scaled > VAL_MAX) begin
      sat_val = VAL_MAX[sla_pkg::VAL_W-1:0];
    end else if (scaled < VAL_MIN) begin
      sat_val = VAL_MIN[sla_pkg::VAL_W-1:0];
    end else begin
      sat_val = scaled[sla_pkg::VAL_W-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) rate_r <= cfg_wdata;
      if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + CW'(1);
      out_valid_r <= cmd.fin;
    end
  end

  // Stores.
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      wall_mem[clr_cnt_r] <= ((clr_cnt_r == '0) || sts.clr_last) ? FULL_ROW : EDGE_ROW;
    end else if (cmd.load_wr && in_grid) begin
      wall_mem[cx_idx][cy_idx] <= item_r.wall_bit;
    end
    wall_row_r <= wall_mem[cx_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && in_grid) begin
      src_mem[{cx_idx, cy_idx}] <= item_r.source_value;
    end
    if (cmd.rd_en) begin
      rdata_r <= src_mem[rd_addr];
    end
  end

  // Arithmetic pipeline.
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.vel_mul) begin
      dispx_prod_r <= $signed({1'b0, rate_r}) * item_r.vel_x;
      dispy_prod_r <= $signed({1'b0, rate_r}) * item_r.vel_y;
    end
    if (cmd.pos_en) begin
      {i0_r, fx_r} <= trace_pos(item_r.cell_x, dispx_prod_r);
      {j0_r, fy_r} <= trace_pos(item_r.cell_y, dispy_prod_r);
      live_r       <= in_grid && !on_border && !wall_row_r[cy_idx];
    end
    if (cmd.wgt_en) begin
      wgt_r[sla_pkg::NB_LL] <= sla_pkg::WGT_W'(sla_pkg::WGT_W'(omx) * sla_pkg::WGT_W'(omy));
      wgt_r[sla_pkg::NB_LH] <= sla_pkg::WGT_W'(sla_pkg::WGT_W'(omx) * sla_pkg::WGT_W'(fy_r));
      wgt_r[sla_pkg::NB_HL] <= sla_pkg::WGT_W'(sla_pkg::WGT_W'(fx_r) * sla_pkg::WGT_W'(omy));
      wgt_r[sla_pkg::NB_HH] <= sla_pkg::WGT_W'(sla_pkg::WGT_W'(fx_r) * sla_pkg::WGT_W'(fy_r));
    end
    if (cmd.mac_en) begin
      mult_r <= $signed({1'b0, wgt_r[cmd.mac_sel]}) * rdata_r;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + sla_pkg::ACC_W'(mult_r);
    end
    if (cmd.fin) begin
      out_data_r.out_x          <= item_r.cell_x;
      out_data_r.out_y          <= item_r.cell_y;
      out_data_r.advected_value <= live_r ? sat_val : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_pos_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pos_en |=> (32'(i0_r) <= GRID_SIZE - 2) && (32'(j0_r) <= GRID_SIZE - 2))
    else $error("interpolation corner outside the clamped range");

  a_dead_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && !live_r) |=> (out_data_r.advected_value == '0))
    else $error("border or wall cell gave a nonzero value");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for semi_lagrangian_advect_cell
// A queue-fed driver sends load and advect transactions with random gaps.
// A clocked monitor keeps its own copy of the source grid, the wall map and
// the backtrace rate, predicts every advected value and compares each strobed
// result with the oldest prediction. The run walks through several rate
// settings, the extremes among them, and pauses until the block is idle
// before each rate change.
// ----------------------------------------------------------------------------
module testbench;

  localparam int GRID         = 128;
  localparam int CELLS        = GRID * GRID;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 24;
  localparam int SHOW_LIMIT   = 60;
  localparam int PHASES       = 5;
  localparam int ITEMS        = 1250;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  sla_pkg::in_item_t          in_data = '0;
  logic                       cfg_we = 1'b0;
  logic [sla_pkg::RATE_W-1:0] cfg_wdata = '0;
  logic                       out_valid;
  sla_pkg::out_item_t         out_data;

  logic signed [sla_pkg::VAL_W-1:0] grid_values [CELLS];
  bit                               grid_walls [CELLS];
  bit                               loaded_cells [CELLS];
  logic [sla_pkg::RATE_W-1:0]       trace_rate = '0;
  sla_pkg::in_item_t                cmd_q [$];
  sla_pkg::out_item_t               advected_q [$];
  int                               mismatches = 0;
  int                               quiet_cycles = 0;
  int                               gap_left = 0;
  int                               pushed = 0;
  bit                               taken = 1'b0;
  bit                               steady = 1'b0;

  semi_lagrangian_advect_cell #(
    .GRID_SIZE(GRID)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic longint trace_axis(logic [sla_pkg::COORD_W-1:0] coord,
                                        logic signed [sla_pkg::VEL_W-1:0] vel,
                                        logic [sla_pkg::RATE_W-1:0] rate);
    longint disp;
    longint pos;
    disp = longint'(rate) * longint'(vel);
    pos = longint'(coord) * 256 - (disp >>> sla_pkg::FRAC_W);
    if (pos < 128) pos = 128;
    else if (pos > GRID * 256 - 384) pos = GRID * 256 - 384;
    return pos;
  endfunction

  function automatic logic signed [sla_pkg::VAL_W-1:0] predict_advect(
    sla_pkg::in_item_t it);
    longint px, py, fx, fy, a, b, c, d, acc;
    int     i0, j0;
    if (it.cell_x == 0 || it.cell_y == 0 || it.cell_x == GRID - 1 ||
        it.cell_y == GRID - 1 || grid_walls[int'(it.cell_x) * GRID + int'(it.cell_y)])
      return '0;
    px = trace_axis(it.cell_x, it.vel_x, trace_rate);
    py = trace_axis(it.cell_y, it.vel_y, trace_rate);
    i0 = int'(px >>> sla_pkg::FRAC_W);
    j0 = int'(py >>> sla_pkg::FRAC_W);
    fx = px & 255;
    fy = py & 255;
    a = longint'(grid_values[i0 * GRID + j0]);
    b = longint'(grid_values[i0 * GRID + j0 + 1]);
    c = longint'(grid_values[(i0 + 1) * GRID + j0]);
    d = longint'(grid_values[(i0 + 1) * GRID + j0 + 1]);
    acc = (256 - fx) * ((256 - fy) * a + fy * b) + fx * ((256 - fy) * c + fy * d);
    acc = (acc + 32768) >>> sla_pkg::RND_SHIFT;
    if (acc > 8388607) acc = 8388607;
    else if (acc < -8388608) acc = -8388608;
    return acc[sla_pkg::VAL_W-1:0];
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < SHOW_LIMIT)
      $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic absorb_item(sla_pkg::in_item_t it);
    sla_pkg::out_item_t res;
    int                 k;
    k = int'(it.cell_x) * GRID + int'(it.cell_y);
    if (it.opcode == sla_pkg::OP_LOAD) begin
      grid_values[k] = it.source_value;
      grid_walls[k] = it.wall_bit;
    end else begin
      res.out_x = it.cell_x;
      res.out_y = it.cell_y;
      res.advected_value = predict_advect(it);
      advected_q.push_back(res);
    end
  endtask

  task automatic check_result(sla_pkg::out_item_t got);
    sla_pkg::out_item_t want;
    if (advected_q.size() == 0) begin
      report_mismatch("result with no transaction outstanding",
                      longint'(got.advected_value), 0);
    end else begin
      want = advected_q.pop_front();
      if (got.out_x !== want.out_x)
        report_mismatch("out_x", longint'(got.out_x), longint'(want.out_x));
      if (got.out_y !== want.out_y)
        report_mismatch("out_y", longint'(got.out_y), longint'(want.out_y));
      if (got.advected_value !== want.advected_value)
        report_mismatch("advected_value", longint'(got.advected_value),
                        longint'(want.advected_value));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) check_result(out_data);
      if (start && !busy) absorb_item(in_data);
      if (cfg_we) trace_rate = cfg_wdata;
    end
    taken <= start && !busy;
    if (out_valid || (start && !busy) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("semi_lagrangian_advect_cell verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int draw_gap();
    int r;
    if (steady) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  always @(negedge clk) begin
    logic              next_start;
    sla_pkg::in_item_t next_data;
    next_start = start;
    next_data = in_data;
    if (start && taken) next_start = 1'b0;
    if (!next_start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() != 0) begin
        next_data = cmd_q.pop_front();
        next_start = 1'b1;
        gap_left = draw_gap();
      end
    end
    start <= next_start;
    in_data <= next_data;
  end

  task automatic push_load(int x, int y, logic [sla_pkg::VAL_W-1:0] v, bit w,
                           int vx, int vy);
    sla_pkg::in_item_t it;
    it = '0;
    it.opcode = sla_pkg::OP_LOAD;
    it.cell_x = sla_pkg::COORD_W'(x);
    it.cell_y = sla_pkg::COORD_W'(y);
    it.source_value = v;
    it.wall_bit = w;
    it.vel_x = sla_pkg::VEL_W'(vx);
    it.vel_y = sla_pkg::VEL_W'(vy);
    loaded_cells[x * GRID + y] = 1'b1;
    cmd_q.push_back(it);
    pushed++;
  endtask

  // For an interior cell, every neighbor that the interpolation will read is loaded first.
  task automatic push_advect(int x, int y, int vx, int vy,
                             logic [sla_pkg::RATE_W-1:0] rate);
    sla_pkg::in_item_t it;
    int                i0, j0;
    if (x > 0 && y > 0 && x < GRID - 1 && y < GRID - 1) begin
      i0 = int'(trace_axis(sla_pkg::COORD_W'(x), sla_pkg::VEL_W'(vx), rate)
                >>> sla_pkg::FRAC_W);
      j0 = int'(trace_axis(sla_pkg::COORD_W'(y), sla_pkg::VEL_W'(vy), rate)
                >>> sla_pkg::FRAC_W);
      for (int di = 0; di < 2; di++) begin
        for (int dj = 0; dj < 2; dj++) begin
          if (!loaded_cells[(i0 + di) * GRID + j0 + dj])
            push_load(i0 + di, j0 + dj, sla_pkg::VAL_W'($urandom()),
                      $urandom_range(0, 11) == 0, int'($urandom()), int'($urandom()));
        end
      end
    end
    it = '0;
    it.opcode = sla_pkg::OP_ADVECT;
    it.cell_x = sla_pkg::COORD_W'(x);
    it.cell_y = sla_pkg::COORD_W'(y);
    it.source_value = sla_pkg::VAL_W'($urandom());
    it.wall_bit = 1'($urandom_range(0, 1));
    it.vel_x = sla_pkg::VEL_W'(vx);
    it.vel_y = sla_pkg::VEL_W'(vy);
    cmd_q.push_back(it);
    pushed++;
  endtask

  task automatic pick_cell(output int x, output int y);
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 70) begin
      x = int'($urandom_range(1, 24));
      y = int'($urandom_range(1, 24));
    end else if (r < 85) begin
      x = int'($urandom_range(1, GRID - 2));
      y = int'($urandom_range(1, GRID - 2));
    end else begin
      x = int'($urandom_range(0, GRID - 1));
      y = int'($urandom_range(0, GRID - 1));
    end
  endtask

  function automatic int pick_vel();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 40) return int'($urandom_range(0, 1023)) - 512;
    if (r < 55) return int'($urandom_range(0, 4)) - 2;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic queue_random_draw(logic [sla_pkg::RATE_W-1:0] rate);
    int x, y;
    pick_cell(x, y);
    if ($urandom_range(0, 99) < 35)
      push_load(x, y, sla_pkg::VAL_W'($urandom()), $urandom_range(0, 7) == 0,
                pick_vel(), pick_vel());
    else
      push_advect(x, y, pick_vel(), pick_vel(), rate);
  endtask

  task automatic queue_directed(logic [sla_pkg::RATE_W-1:0] rate);
    push_load(1, 1, 24'h7FFFFF, 1'b0, -32768, 32767);
    push_load(2, 1, 24'h800000, 1'b0, 32767, -32768);
    push_load(1, 2, 24'h000001, 1'b0, 0, 0);
    push_load(2, 2, 24'hFFFFFF, 1'b0, 0, 0);
    push_advect(1, 1, 0, 0, rate);
    push_advect(2, 1, 128, 0, rate);
    push_advect(2, 2, 128, 128, rate);
    push_advect(1, 1, -1, 1, rate);
    push_advect(0, 64, 0, 0, rate);
    push_advect(127, 5, 0, 0, rate);
    push_advect(9, 0, 0, 0, rate);
    push_advect(9, 127, 0, 0, rate);
    // A border cell stays at zero even once its wall bit is cleared.
    push_load(0, 0, 24'h123456, 1'b0, 0, 0);
    push_advect(0, 0, 0, 0, rate);
    push_load(5, 5, 24'h345678, 1'b1, 0, 0);
    push_advect(5, 5, 0, 0, rate);
    push_load(5, 5, 24'h345678, 1'b0, 0, 0);
    push_advect(5, 5, 0, 0, rate);
    push_advect(64, 64, 32767, -32768, rate);
    push_advect(126, 126, -32768, 32767, rate);
    push_advect(1, 126, 32767, 32767, rate);
  endtask

  task automatic write_rate(logic [sla_pkg::RATE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Loads give no result, so the block may still be busy after the last one.
  task automatic wait_idle();
    while (cmd_q.size() != 0 || start || advected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [sla_pkg::RATE_W-1:0] rate;
    for (int k = 0; k < CELLS; k++) begin
      grid_values[k] = '0;
      grid_walls[k] = (k / GRID == 0) || (k % GRID == 0) ||
                      (k / GRID == GRID - 1) || (k % GRID == GRID - 1);
      loaded_cells[k] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) wait_idle();
      case (ph)
        0: rate = 16'h0100;
        1: rate = 16'h0000;
        2: rate = 16'hFFFF;
        3: rate = sla_pkg::RATE_W'($urandom_range(1, 65534));
        default: rate = sla_pkg::RATE_W'($urandom_range(1, 512));
      endcase
      write_rate(rate);
      steady = (ph == 2);
      if (ph == 0) queue_directed(rate);
      while (pushed < (ph + 1) * ITEMS / PHASES) queue_random_draw(rate);
    end
    wait_idle();
    if (advected_q.size() != 0)
      report_mismatch("transactions still outstanding", longint'(advected_q.size()), 0);
    if (mismatches == 0) begin
      $display("semi_lagrangian_advect_cell verification clean");
    end else begin
      $display("semi_lagrangian_advect_cell verification failed");
    end
    $finish;
  end

endmodule
